// ===== sv/fca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fca_pkg
// Shared types and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;

	localparam int NUM_CLUSTERS_DEF = 4096;
	localparam int PTR_BITS_DEF     = 16;

	localparam int CMD_W  = 3;
	localparam int CNT_W  = 13;
	localparam int CLU_W  = 16;
	localparam int PTR_W  = 16;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_FREE    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_READ    = 3'd3,
		CMD_SETFREE = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_SENTINEL = 2'd2,
		ST_TOOLONG  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_WALK = 2'd2,
		S_RESP = 2'd3
	} state_t;

	typedef struct packed {
		logic [PTR_W-1:0] pointer;
		status_t          status;
		logic [CNT_W-1:0] free_left;
		logic [CNT_W-1:0] chain_length;
	} result_t;

endpackage
`default_nettype wire

// ===== sv/fca_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fca_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/fca_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fca_engine
// Command sequencer: walks chains through the next-pointer RAM one entry per
// cycle and keeps the free-list head and free count.
// ----------------------------------------------------------------------------
module fca_engine
	import fca_pkg::*;
#(
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
	parameter int PTR_BITS     = PTR_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire logic [CMD_W-1:0]                cmd,
	input  wire logic [CNT_W-1:0]                count,
	input  wire logic [CLU_W-1:0]                cluster,
	input  wire logic [CLU_W-1:0]                entry_value,
	output logic                                 rd_en,
	output logic      [$clog2(NUM_CLUSTERS)-1:0] rd_addr,
	input  wire logic [PTR_BITS-1:0]             rd_data,
	output logic                                 wr_en,
	output logic      [$clog2(NUM_CLUSTERS)-1:0] wr_addr,
	output logic      [PTR_BITS-1:0]             wr_data,
	output logic                                 res_valid,
	input  wire logic                            res_ready,
	output result_t                              res
);

	localparam int AW = $clog2(NUM_CLUSTERS);
	localparam int LW = $clog2(NUM_CLUSTERS + 1);
	localparam int SW = ((LW > CNT_W) ? LW : CNT_W) + 1;
	localparam int CW = ((PTR_BITS > 17) ? PTR_BITS : 17) + 1;

	localparam logic [PTR_BITS-1:0] MARK_LAST     = '1;
	localparam logic [PTR_BITS-1:0] MARK_INVALID  = MARK_LAST - PTR_BITS'(1);
	localparam logic [PTR_BITS-1:0] MARK_RESERVED = MARK_LAST - PTR_BITS'(2);
	localparam logic [CNT_W-1:0]    CNT_CAP       =
		(NUM_CLUSTERS < 8191) ? CNT_W'(NUM_CLUSTERS) : CNT_MAX;

	function automatic logic in_table(input logic [PTR_BITS-1:0] p);
		return CW'(p) < CW'(NUM_CLUSTERS);
	endfunction

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PTR_BITS-1:0]  clus_q;
	logic [PTR_BITS-1:0]  val_q;
	logic [PTR_BITS-1:0]  cur_q;
	logic [CNT_W-1:0]     k_q;
	logic [LW-1:0]        len_q;
	logic [PTR_BITS-1:0]  free_head_q;
	logic [CNT_W-1:0]     free_count_q;
	logic [PTR_BITS-1:0]  res_ptr_q;
	status_t              res_status_q;
	logic [CNT_W-1:0]     res_chain_q;

	logic                 nx_in_table;
	logic [PTR_BITS-1:0]  nx;
	logic                 alloc_bad;
	logic                 clus_sentinel;
	logic                 walk_done;
	logic                 free_ok;
	logic                 needs_walk;
	logic [SW-1:0]        free_sum;
	logic [CNT_W-1:0]     free_sum_cap;
	logic [CNT_W-1:0]     set_count_cap;

	// A pointer outside the table reads as the end of the chain.
	assign nx          = in_table(cur_q) ? rd_data : MARK_LAST;
	assign nx_in_table = in_table(nx);
	assign alloc_bad   = (cnt_q == '0) || (cnt_q > free_count_q);
	assign clus_sentinel = (clus_q == MARK_INVALID) || (clus_q == MARK_RESERVED) ||
		(clus_q == MARK_LAST) || !in_table(clus_q);
	assign free_ok     = (nx == MARK_LAST);

	assign free_sum      = SW'(free_count_q) + SW'(len_q);
	assign free_sum_cap  = (free_sum > SW'(CNT_CAP)) ? CNT_CAP : CNT_W'(free_sum);
	assign set_count_cap = (cnt_q > CNT_CAP) ? CNT_CAP : cnt_q;

	always_comb begin
		case (cmd_q)
			CMD_ALLOC: needs_walk = !alloc_bad;
			CMD_FREE:  needs_walk = !clus_sentinel;
			CMD_READ:  needs_walk = 1'b1;
			default:   needs_walk = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd_q)
			CMD_ALLOC: walk_done = (k_q == CNT_W'(1));
			CMD_FREE:  walk_done = free_ok || !nx_in_table || (len_q >= LW'(NUM_CLUSTERS));
			default:   walk_done = 1'b1;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_EXEC;
			S_EXEC: state_d = needs_walk ? S_WALK : S_RESP;
			S_WALK: if (walk_done) state_d = S_RESP;
			S_RESP: if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port and handshake outputs.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = AW'(cur_q);
		wr_en     = 1'b0;
		wr_addr   = AW'(cur_q);
		wr_data   = free_head_q;
		req_stall = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
			end
			S_EXEC: begin
				if (cmd_q == CMD_WRITE) begin
					wr_en   = in_table(clus_q);
					wr_addr = AW'(clus_q);
					wr_data = val_q;
				end else begin
					rd_en = needs_walk;
				end
			end
			S_WALK: begin
				if (!walk_done) begin
					rd_en   = 1'b1;
					rd_addr = AW'(nx);
				end else if (cmd_q == CMD_ALLOC) begin
					wr_en   = in_table(cur_q);
					wr_data = MARK_LAST;
				end else if (cmd_q == CMD_FREE) begin
					wr_en   = free_ok;
					wr_data = free_head_q;
				end
			end
			S_RESP: begin
				res_valid = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_head_q  <= MARK_LAST;
			free_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC && cmd_q == CMD_SETFREE) begin
				free_head_q  <= clus_q;
				free_count_q <= set_count_cap;
			end
			if (state_q == S_WALK && walk_done) begin
				if (cmd_q == CMD_ALLOC) begin
					free_head_q  <= nx;
					free_count_q <= free_count_q - cnt_q;
				end else if (cmd_q == CMD_FREE && free_ok) begin
					free_head_q  <= clus_q;
					free_count_q <= free_sum_cap;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_q  <= cmd_t'(cmd);
					cnt_q  <= count;
					clus_q <= PTR_BITS'(cluster);
					val_q  <= PTR_BITS'(entry_value);
					cur_q  <= (cmd_t'(cmd) == CMD_ALLOC) ? free_head_q : PTR_BITS'(cluster);
				end
			end
			S_EXEC: begin
				k_q          <= cnt_q;
				len_q        <= LW'(1);
				res_ptr_q    <= '0;
				res_status_q <= ST_OK;
				res_chain_q  <= '0;
				if (cmd_q == CMD_ALLOC && alloc_bad) begin
					res_status_q <= ST_NOSPACE;
					res_ptr_q    <= MARK_INVALID;
				end
				if (cmd_q == CMD_FREE && clus_sentinel) begin
					res_status_q <= ST_SENTINEL;
				end
			end
			S_WALK: begin
				case (cmd_q)
					CMD_ALLOC: begin
						k_q <= k_q - CNT_W'(1);
						if (walk_done) begin
							res_ptr_q <= free_head_q;
						end else begin
							cur_q <= nx;
						end
					end
					CMD_FREE: begin
						if (free_ok) begin
							res_chain_q <= CNT_W'(len_q);
						end else if (walk_done) begin
							res_status_q <= ST_TOOLONG;
						end else begin
							len_q <= len_q + LW'(1);
							cur_q <= nx;
						end
					end
					CMD_READ: begin
						res_ptr_q <= nx;
					end
					default: begin
						res_ptr_q <= '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign res.pointer      = PTR_W'(res_ptr_q);
	assign res.status       = res_status_q;
	assign res.free_left    = free_count_q;
	assign res.chain_length = res_chain_q;

`ifndef SYNTHESIS
	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_CAP)
		else $error("free count above its cap");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("table read and write in the same cycle");

	a_alloc_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && cmd_q == CMD_ALLOC) |-> (k_q != '0))
		else $error("allocation walk ran past its count");

	a_free_links: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && cmd_q == CMD_FREE && free_ok) |=>
			(free_head_q == $past(clus_q)) && (state_q == S_RESP))
		else $error("freed chain not placed at the head of the free list");
`endif

endmodule
`default_nettype wire

// ===== sv/fca_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fca_out_stage
// Result register between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module fca_out_stage
	import fca_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	output logic                   res_ready,
	input  wire result_t           res,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic     [PTR_W-1:0]   pointer,
	output logic     [STAT_W-1:0]  status,
	output logic     [CNT_W-1:0]   free_left,
	output logic     [CNT_W-1:0]   chain_length
);

	logic    valid_q;
	result_t data_q;

	// A new result may enter once the held one is gone or leaves this cycle.
	assign res_ready = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	assign rsp_valid    = valid_q;
	assign pointer      = data_q.pointer;
	assign status       = data_q.status;
	assign free_left    = data_q.free_left;
	assign chain_length = data_q.chain_length;

endmodule
`default_nettype wire

// ===== sv/fat_chain_free_list_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_free_list_allocator
// Cluster chain allocator over a next-pointer table with a free list.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the req channel (req_valid / req_stall, fields cmd, count,
// cluster, entry_value); each produces exactly one result on the rsp channel
// (rsp_valid / rsp_stall, fields pointer, status, free_left, chain_length).
// A transfer happens at a clock edge with valid high and stall low.
// Commands are handled one at a time. Walks follow the table through one
// synchronous RAM, one entry per cycle. A command passes an execute state,
// then a walk state for allocations, frees and reads that are not rejected,
// then a response state. The result shows on rsp_valid in the same cycle
// in which the next command can be taken.
// The result sits in an output register; while the receiver stalls it holds
// there and the block still takes and processes the next command, which then
// waits for that register to drain.
// Reset empties the free list (head at the last marker, count zero) and
// drops any pending result. The table itself is not cleared; load it with
// write commands before use.
// ----------------------------------------------------------------------------
module fat_chain_free_list_allocator
	import fca_pkg::*;
#(
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
	parameter int PTR_BITS     = PTR_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [CNT_W-1:0]  count,
	input  wire logic [CLU_W-1:0]  cluster,
	input  wire logic [CLU_W-1:0]  entry_value,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [PTR_W-1:0]  pointer,
	output logic      [STAT_W-1:0] status,
	output logic      [CNT_W-1:0]  free_left,
	output logic      [CNT_W-1:0]  chain_length
);

	localparam int AW = $clog2(NUM_CLUSTERS);

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [PTR_BITS-1:0] rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [PTR_BITS-1:0] wr_data;
	logic                res_valid;
	logic                res_ready;
	result_t             res;

	fca_ram #(
		.WIDTH (PTR_BITS),
		.DEPTH (NUM_CLUSTERS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fca_engine #(
		.NUM_CLUSTERS (NUM_CLUSTERS),
		.PTR_BITS     (PTR_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.count       (count),
		.cluster     (cluster),
		.entry_value (entry_value),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	fca_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.pointer      (pointer),
		.status       (status),
		.free_left    (free_left),
		.chain_length (chain_length)
	);

endmodule
`default_nettype wire

// ===== sim/tb_fat_chain_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_chain_free_list_allocator
// Self-checking testbench for the cluster chain allocator. Commands are driven
// on the request channel with random gaps and the results are checked field by
// field against a model of the next-pointer table and the free list kept here.
// Directed tests cover the corner cases, then random traffic builds, allocates
// and frees chains under random backpressure.
// ----------------------------------------------------------------------------
module tb_fat_chain_free_list_allocator;
	import fca_pkg::*;

	localparam int N_CLUS = NUM_CLUSTERS_DEF;
	localparam int COUNT_CAP = (N_CLUS < 8191) ? N_CLUS : 8191;
	localparam logic [PTR_W-1:0] MARK_LAST = 16'hFFFF;
	localparam logic [PTR_W-1:0] MARK_INVALID = 16'hFFFE;
	localparam logic [PTR_W-1:0] MARK_RESERVED = 16'hFFFD;
	localparam int SHORT_WALK = 40;
	localparam int POOL_SIZE = 48;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [CMD_W-1:0]  cmd;
	logic [CNT_W-1:0]  count;
	logic [CLU_W-1:0]  cluster;
	logic [CLU_W-1:0]  entry_value;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [PTR_W-1:0]  pointer;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  free_left;
	logic [CNT_W-1:0]  chain_length;

	fat_chain_free_list_allocator #(
		.NUM_CLUSTERS(N_CLUS),
		.PTR_BITS(PTR_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd(cmd),
		.count(count),
		.cluster(cluster),
		.entry_value(entry_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.pointer(pointer),
		.status(status),
		.free_left(free_left),
		.chain_length(chain_length)
	);

	// Shadow of the table, the free list and the chains handed out so far.
	logic [PTR_W-1:0] fat_next [N_CLUS];
	bit               fat_known [N_CLUS];
	int unsigned      known_idx [$];
	logic [PTR_W-1:0] fl_head;
	int               fl_count;
	logic [CLU_W-1:0] taken_heads [$];
	result_t          expected_results [$];

	int mismatches = 0;
	bit no_idle = 1'b0;
	int rsp_hold = 0;
	int rsp_wait = 0;
	int long_walks_left = 8;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb_fat_chain_free_list_allocator: errors");
		$finish;
	end

	function automatic logic [PTR_W-1:0] fat_read(input int unsigned idx);
		if (idx >= N_CLUS)
			return MARK_LAST;
		return fat_next[idx];
	endfunction

	function automatic bit fat_readable(input int unsigned idx);
		return idx >= N_CLUS || fat_known[idx];
	endfunction

	function automatic void fat_write(input int unsigned idx, input logic [PTR_W-1:0] val);
		if (idx < N_CLUS) begin
			if (!fat_known[idx])
				known_idx.push_back(idx);
			fat_known[idx] = 1'b1;
			fat_next[idx] = val;
		end
	endfunction

	function automatic bit is_sentinel(input logic [CLU_W-1:0] clus);
		return clus == MARK_LAST || clus == MARK_INVALID || clus == MARK_RESERVED ||
			clus >= N_CLUS;
	endfunction

	// Applies one command to the shadow state and returns the result it gives.
	function automatic result_t predict_cmd(input logic [CMD_W-1:0] c,
			input logic [CNT_W-1:0] cnt, input logic [CLU_W-1:0] clus,
			input logic [CLU_W-1:0] val);
		result_t          r;
		logic [PTR_W-1:0] tail;
		logic [PTR_W-1:0] nx;
		int               len;
		bit               closed;
		bit               walking;
		r = '0;
		r.status = ST_OK;
		case (c)
		CMD_ALLOC: begin
			if (cnt == 0 || cnt > fl_count) begin
				r.status = ST_NOSPACE;
				r.pointer = MARK_INVALID;
			end else begin
				tail = fl_head;
				for (int i = 1; i < cnt; i++)
					tail = fat_read(tail);
				fl_count -= cnt;
				r.pointer = fl_head;
				fl_head = fat_read(tail);
				fat_write(tail, MARK_LAST);
				taken_heads.push_back(r.pointer);
			end
		end
		CMD_FREE: begin
			if (is_sentinel(clus)) begin
				r.status = ST_SENTINEL;
			end else begin
				tail = clus;
				len = 1;
				closed = 1'b0;
				walking = 1'b1;
				while (walking) begin
					nx = fat_read(tail);
					if (nx == MARK_LAST) begin
						closed = 1'b1;
						walking = 1'b0;
					end else if (nx >= N_CLUS || len >= N_CLUS) begin
						walking = 1'b0;
					end else begin
						len++;
						tail = nx;
					end
				end
				if (!closed) begin
					r.status = ST_TOOLONG;
				end else begin
					fat_write(tail, fl_head);
					fl_head = clus;
					fl_count = (fl_count + len > COUNT_CAP) ? COUNT_CAP : fl_count + len;
					r.chain_length = CNT_W'(len);
					for (int k = taken_heads.size() - 1; k >= 0; k--)
						if (taken_heads[k] == clus)
							taken_heads.delete(k);
				end
			end
		end
		CMD_WRITE: fat_write(clus, val);
		CMD_READ: r.pointer = fat_read(clus);
		CMD_SETFREE: begin
			fl_head = clus;
			fl_count = (cnt > COUNT_CAP) ? COUNT_CAP : cnt;
		end
		default: ;
		endcase
		r.free_left = CNT_W'(fl_count);
		return r;
	endfunction

	// Number of table reads an allocation or free would make (zero otherwise),
	// or -1 if the command would read an entry that was never written.
	function automatic int walk_cost(input logic [CMD_W-1:0] c, input logic [CNT_W-1:0] cnt,
			input logic [CLU_W-1:0] clus);
		int               n;
		logic [PTR_W-1:0] tail;
		logic [PTR_W-1:0] nx;
		bit               walking;
		n = 0;
		if (c == CMD_ALLOC && cnt != 0 && cnt <= fl_count) begin
			tail = fl_head;
			for (int i = 1; i < cnt; i++) begin
				if (!fat_readable(tail))
					return -1;
				tail = fat_read(tail);
			end
			if (!fat_readable(tail))
				return -1;
			n = cnt;
		end else if (c == CMD_FREE && !is_sentinel(clus)) begin
			tail = clus;
			n = 1;
			walking = 1'b1;
			while (walking) begin
				if (!fat_readable(tail))
					return -1;
				nx = fat_read(tail);
				if (nx == MARK_LAST || nx >= N_CLUS || n >= N_CLUS) begin
					walking = 1'b0;
				end else begin
					n++;
					tail = nx;
				end
			end
		end else if (c == CMD_READ && !fat_readable(clus)) begin
			n = -1;
		end
		return n;
	endfunction

	// Drives one command, waits for its transfer, then idles for a random gap unless no_idle is set.
	task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [CNT_W-1:0] cnt,
			input logic [CLU_W-1:0] clus, input logic [CLU_W-1:0] val);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		cmd <= c;
		count <= cnt;
		cluster <= clus;
		entry_value <= val;
		do @(posedge clk); while (req_stall);
		expected_results.push_back(predict_cmd(c, cnt, clus, val));
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// The sender goes quiet until every outstanding result has come back.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_alloc_and_free();
		send_cmd(CMD_WRITE, 13'd0, 16'd0, 16'd1);
		send_cmd(CMD_WRITE, 13'd0, 16'd1, 16'd2);
		send_cmd(CMD_WRITE, 13'd0, 16'd2, 16'd3);
		send_cmd(CMD_WRITE, 13'd0, 16'd3, MARK_LAST);
		send_cmd(CMD_SETFREE, 13'd4, 16'd0, 16'd0);
		send_cmd(CMD_ALLOC, 13'd0, 16'd0, 16'd0);
		send_cmd(CMD_ALLOC, 13'd5, 16'd0, 16'd0);
		send_cmd(CMD_ALLOC, 13'd2, 16'd0, 16'd0);
		send_cmd(CMD_READ, 13'd0, 16'd1, 16'd0);
		send_cmd(CMD_FREE, 13'd0, 16'd0, 16'd0);
		// Takes the whole free list, which leaves it empty.
		send_cmd(CMD_ALLOC, 13'd4, 16'd0, 16'd0);
		settle();
	endtask

	task automatic test_sentinels_and_bounds();
		send_cmd(CMD_FREE, 13'd0, MARK_LAST, 16'd0);
		send_cmd(CMD_FREE, 13'd0, MARK_INVALID, 16'd0);
		send_cmd(CMD_FREE, 13'd0, MARK_RESERVED, 16'd0);
		send_cmd(CMD_FREE, 13'd0, 16'(N_CLUS), 16'd0);
		send_cmd(CMD_WRITE, 13'd0, 16'hC000, 16'h1234);
		send_cmd(CMD_READ, 13'd0, 16'hFFFF, 16'd0);
		// A pointer past the table that is not the last marker breaks the chain.
		send_cmd(CMD_WRITE, 13'd0, 16'(N_CLUS - 1), MARK_INVALID);
		send_cmd(CMD_FREE, 13'd0, 16'(N_CLUS - 1), 16'd0);
		send_cmd(CMD_W'(5), 13'h1FFF, 16'hFFFF, 16'hFFFF);
		send_cmd(CMD_W'(7), 13'h1FFF, 16'hFFFF, 16'hFFFF);
		// Head outside the table with a count above the cap: the allocation
		// follows the bogus list and the following free saturates the count.
		send_cmd(CMD_SETFREE, 13'h1FFF, 16'd65000, 16'd0);
		send_cmd(CMD_ALLOC, 13'd3, 16'd0, 16'd0);
		send_cmd(CMD_FREE, 13'd0, 16'd0, 16'd0);
		settle();
	endtask

	task automatic test_looping_chain();
		send_cmd(CMD_WRITE, 13'd0, 16'd20, 16'd20);
		send_cmd(CMD_FREE, 13'd0, 16'd20, 16'd0);
		settle();
	endtask

	task automatic test_output_backpressure();
		rsp_hold = 80;
		no_idle = 1'b1;
		repeat (10)
			send_cmd(CMD_READ, CNT_W'($urandom), CLU_W'(known_idx[$urandom_range(0,
				known_idx.size() - 1)]), CLU_W'($urandom));
		no_idle = 1'b0;
		settle();
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [CLU_W-1:0] pool [$];
		logic [CLU_W-1:0] fresh [$];
		bit               seen [int unsigned];
		logic [CMD_W-1:0] c;
		logic [CNT_W-1:0] cnt;
		logic [CLU_W-1:0] clus;
		logic [CLU_W-1:0] val;
		int unsigned      idx;
		int               sent;
		int               pick;
		int               r2;
		int               cost;
		int               k;
		bit               found;
		bit               donate;

		// Link a pool of scattered clusters into a fresh free list.
		pool.push_back(16'(N_CLUS - 1));
		pool.push_back(16'd0);
		seen[N_CLUS - 1] = 1'b1;
		seen[0] = 1'b1;
		while (pool.size() < POOL_SIZE) begin
			idx = $urandom_range(0, N_CLUS - 1);
			if (!seen.exists(idx)) begin
				seen[idx] = 1'b1;
				pool.push_back(CLU_W'(idx));
			end
		end
		for (int i = 0; i < POOL_SIZE; i++)
			send_cmd(CMD_WRITE, CNT_W'($urandom), pool[i],
				(i == POOL_SIZE - 1) ? MARK_LAST : pool[i + 1]);
		send_cmd(CMD_SETFREE, CNT_W'(POOL_SIZE), pool[0], CLU_W'($urandom));
		taken_heads.delete();
		sent = POOL_SIZE + 1;

		while (sent < n_items) begin
			no_idle = ((sent / 100) % 4) == 3;
			found = 1'b0;
			donate = 1'b0;
			cost = 0;
			while (!found) begin
				pick = $urandom_range(0, 99);
				r2 = $urandom_range(0, 9);
				cnt = CNT_W'($urandom);
				clus = CLU_W'($urandom);
				val = CLU_W'($urandom);
				if (pick < 30) begin
					c = CMD_ALLOC;
					if (fl_count > 0 && r2 < 8)
						cnt = CNT_W'($urandom_range(1, (fl_count < 8) ? fl_count : 8));
					else if (r2 == 8)
						cnt = '0;
				end else if (pick < 55) begin
					c = CMD_FREE;
					if (taken_heads.size() != 0 && r2 < 7)
						clus = taken_heads[$urandom_range(0, taken_heads.size() - 1)];
					else if (r2 < 8)
						clus = MARK_LAST - CLU_W'($urandom_range(0, 2));
					else if (r2 == 8)
						clus = CLU_W'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
				end else if (pick < 67) begin
					c = CMD_READ;
					if (r2 < 7)
						clus = CLU_W'(known_idx[$urandom_range(0, known_idx.size() - 1)]);
				end else if (pick < 80) begin
					c = CMD_WRITE;
					if (r2 < 5)
						clus = CLU_W'($urandom_range(0, N_CLUS - 1));
					if (r2 % 3 == 0)
						val = MARK_LAST;
				end else if (pick < 86) begin
					c = CMD_SETFREE;
					if (r2 < 5) begin
						clus = fl_head;
						cnt = CNT_W'(fl_count);
					end else if (r2 < 8 && taken_heads.size() != 0) begin
						clus = taken_heads[$urandom_range(0, taken_heads.size() - 1)];
						cnt = CNT_W'($urandom_range(1, 6));
					end
				end else if (pick < 92) begin
					c = CMD_W'($urandom_range(5, 7));
				end else begin
					donate = 1'b1;
				end
				if (donate) begin
					found = 1'b1;
				end else begin
					cost = walk_cost(c, cnt, clus);
					found = cost >= 0 && (cost <= SHORT_WALK ||
						(long_walks_left > 0 && $urandom_range(0, 49) == 0));
				end
			end

			if (donate) begin
				// Build a short chain on clusters never used and hand it to
				// the free list.
				fresh.delete();
				k = $urandom_range(1, 6);
				while (fresh.size() < k) begin
					idx = $urandom_range(0, N_CLUS - 1);
					if (!fat_known[idx] && !seen.exists(idx)) begin
						seen[idx] = 1'b1;
						fresh.push_back(CLU_W'(idx));
					end
				end
				for (int i = 0; i < k; i++)
					send_cmd(CMD_WRITE, CNT_W'($urandom), fresh[i],
						(i == k - 1) ? MARK_LAST : fresh[i + 1]);
				send_cmd(CMD_FREE, CNT_W'($urandom), fresh[0], CLU_W'($urandom));
				sent += k + 1;
			end else begin
				if (cost > SHORT_WALK)
					long_walks_left--;
				send_cmd(c, cnt, clus, val);
				sent++;
			end
		end
		no_idle = 1'b0;
		settle();
	endtask

	// Receiver: random stall after each transfer, or a long hold on request.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (rsp_hold - 1) @(negedge clk);
				rsp_hold = 0;
			end else begin
				rsp_stall <= (rsp_wait > 0);
				if (rsp_wait > 0)
					rsp_wait--;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_wait = no_idle ? 0 : $urandom_range(0, 5);
			if (expected_results.size() == 0) begin
				$error("result with nothing outstanding: pointer %h status %0d", pointer, status);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (pointer !== want.pointer) begin
					$error("pointer: expected %h, got %h", want.pointer, pointer);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (free_left !== want.free_left) begin
					$error("free_left: expected %0d, got %0d", want.free_left, free_left);
					mismatches++;
				end
				if (chain_length !== want.chain_length) begin
					$error("chain_length: expected %0d, got %0d", want.chain_length,
						chain_length);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = '0;
		count = '0;
		cluster = '0;
		entry_value = '0;
		fl_head = MARK_LAST;
		fl_count = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_alloc_and_free();
		test_sentinels_and_bounds();
		test_looping_chain();
		test_output_backpressure();
		test_random_traffic(850);

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_fat_chain_free_list_allocator: clean");
		else
			$display("tb_fat_chain_free_list_allocator: errors");
		$finish;
	end

endmodule
